// ===== src/point_in_triangle_union_defines.svh =====
// Assertion macros used by the point_in_triangle_union controller.
`ifndef POINT_IN_TRIANGLE_UNION_DEFINES_SVH
`define POINT_IN_TRIANGLE_UNION_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold on every rising clock edge outside reset.
`define PITU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pitu: property failed");
// Condition must never be seen outside reset.
`define PITU_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("pitu: forbidden condition seen");
`else
`define PITU_ASSERT(lbl, prop)
`define PITU_ASSERT_NEVER(lbl, prop)
`endif
`endif

// ===== src/pitu_pkg.sv =====
// Types and constants of the point-in-triangle-union block.
`default_nettype none
package pitu_pkg;

  localparam int unsigned COORD_BITS        = 16;
  localparam int unsigned MAX_TRIANGLES_DEF = 16;
  localparam int unsigned SLOT_W            = 4;
  localparam int unsigned COUNT_W           = 5;
  localparam int unsigned TOL_W             = 20;
  localparam int unsigned CFG_DATA_W        = 20;
  localparam int unsigned VTX_W             = 2 * COORD_BITS;

  typedef enum logic {
    CFG_TRI_COUNT = 1'b0,
    CFG_TOLERANCE = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic              req_type;
    logic [SLOT_W-1:0] slot;
    coord_t            ax;
    coord_t            ay;
    coord_t            bx;
    coord_t            by_coord;
    coord_t            cx;
    coord_t            cy;
    coord_t            point_x;
    coord_t            point_y;
  } pitu_req_t;

  typedef struct packed {
    logic is_reply;
    logic inside_res;
  } pitu_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic write;   // store the request's triangle
    logic start;   // latch query point, clear hit flag
    logic issue;   // read one slot into the pipeline
  } pitu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;
    logic hit;
  } pitu_sts_t;

endpackage
`default_nettype wire

// ===== src/pitu_dp.sv =====
// Datapath: triangle store and pipelined doubled-area membership test.
`default_nettype none
module pitu_dp #(
  parameter int unsigned MAX_TRIANGLES = pitu_pkg::MAX_TRIANGLES_DEF,
  localparam int unsigned IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pitu_pkg::pitu_cmd_t       cmd_i,
  input  wire pitu_pkg::pitu_req_t       req_i,
  input  wire logic [IDX_W-1:0]          rd_idx_i,
  input  wire logic [pitu_pkg::TOL_W-1:0] tol_i,
  output pitu_pkg::pitu_sts_t            sts_o
);
  import pitu_pkg::*;

  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned AREA_W = PROD_W;
  localparam int unsigned SUM_W  = AREA_W + 2;
  localparam int unsigned MIS_W  = AREA_W + 3;
  localparam int unsigned ADR_W  = IDX_W + SLOT_W;

  logic [VTX_W-1:0] vtx_a_mem [MAX_TRIANGLES];
  logic [VTX_W-1:0] vtx_b_mem [MAX_TRIANGLES];
  logic [VTX_W-1:0] vtx_c_mem [MAX_TRIANGLES];

  logic [ADR_W-1:0] slot_ext;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_en;

  assign slot_ext = ADR_W'(req_i.slot);
  assign wr_idx   = slot_ext[IDX_W-1:0];
  assign wr_en    = cmd_i.write && (slot_ext < ADR_W'(MAX_TRIANGLES));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vtx_a_mem[wr_idx] <= {req_i.ax, req_i.ay};
      vtx_b_mem[wr_idx] <= {req_i.bx, req_i.by_coord};
      vtx_c_mem[wr_idx] <= {req_i.cx, req_i.cy};
    end
  end

  // query point
  coord_t px_q, py_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= req_i.point_x;
      py_q <= req_i.point_y;
    end
  end

  // stage valids
  logic [4:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], cmd_i.issue};
    end
  end

  // stage 0: registered memory read
  logic [VTX_W-1:0] rd_a_q, rd_b_q, rd_c_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_a_q <= vtx_a_mem[rd_idx_i];
      rd_b_q <= vtx_b_mem[rd_idx_i];
      rd_c_q <= vtx_c_mem[rd_idx_i];
    end
  end

  coord_t ax, ay, bx, by, cx, cy;
  assign ax = rd_a_q[VTX_W-1 -: COORD_BITS];
  assign ay = rd_a_q[COORD_BITS-1:0];
  assign bx = rd_b_q[VTX_W-1 -: COORD_BITS];
  assign by = rd_b_q[COORD_BITS-1:0];
  assign cx = rd_c_q[VTX_W-1 -: COORD_BITS];
  assign cy = rd_c_q[COORD_BITS-1:0];

  // stage 1: edge and point-relative differences
  // 0/1: B-A, 2/3: C-A, 4/5: A-P, 6/7: B-P, 8/9: C-P (x then y)
  logic signed [DIFF_W-1:0] d_q [10];
  always_ff @(posedge clk_i) begin
    if (v_q[0]) begin
      d_q[0] <= DIFF_W'(bx) - DIFF_W'(ax);
      d_q[1] <= DIFF_W'(by) - DIFF_W'(ay);
      d_q[2] <= DIFF_W'(cx) - DIFF_W'(ax);
      d_q[3] <= DIFF_W'(cy) - DIFF_W'(ay);
      d_q[4] <= DIFF_W'(ax) - DIFF_W'(px_q);
      d_q[5] <= DIFF_W'(ay) - DIFF_W'(py_q);
      d_q[6] <= DIFF_W'(bx) - DIFF_W'(px_q);
      d_q[7] <= DIFF_W'(by) - DIFF_W'(py_q);
      d_q[8] <= DIFF_W'(cx) - DIFF_W'(px_q);
      d_q[9] <= DIFF_W'(cy) - DIFF_W'(py_q);
    end
  end

  // stage 2: cross-product terms, two per triangle area
  logic signed [PROD_W-1:0] p_q [8];
  always_ff @(posedge clk_i) begin
    if (v_q[1]) begin
      p_q[0] <= PROD_W'(d_q[0]) * PROD_W'(d_q[3]);  // whole
      p_q[1] <= PROD_W'(d_q[1]) * PROD_W'(d_q[2]);
      p_q[2] <= PROD_W'(d_q[4]) * PROD_W'(d_q[7]);  // ABP
      p_q[3] <= PROD_W'(d_q[5]) * PROD_W'(d_q[6]);
      p_q[4] <= PROD_W'(d_q[6]) * PROD_W'(d_q[9]);  // BCP
      p_q[5] <= PROD_W'(d_q[7]) * PROD_W'(d_q[8]);
      p_q[6] <= PROD_W'(d_q[4]) * PROD_W'(d_q[9]);  // ACP
      p_q[7] <= PROD_W'(d_q[5]) * PROD_W'(d_q[8]);
    end
  end

  // stage 3: absolute doubled areas
  logic signed [PROD_W:0] cross_d [4];
  logic        [AREA_W-1:0] area_q [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cross_d[k] = (PROD_W+1)'(p_q[2*k]) - (PROD_W+1)'(p_q[2*k+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_q[2]) begin
      for (int k = 0; k < 4; k++) begin
        area_q[k] <= cross_d[k][PROD_W] ? AREA_W'(-cross_d[k]) : AREA_W'(cross_d[k]);
      end
    end
  end

  // stage 4: sum of the three sub-areas
  logic [AREA_W-1:0] whole_q;
  logic [SUM_W-1:0]  parts_q;
  always_ff @(posedge clk_i) begin
    if (v_q[3]) begin
      whole_q <= area_q[0];
      parts_q <= SUM_W'(area_q[1]) + SUM_W'(area_q[2]) + SUM_W'(area_q[3]);
    end
  end

  // stage 5: mismatch against tolerance, OR into hit flag
  logic signed [MIS_W-1:0] mis;
  logic        [MIS_W-1:0] mis_mag;
  logic                    in_tri;
  logic                    hit_q;

  assign mis     = $signed(MIS_W'(whole_q)) - $signed(MIS_W'(parts_q));
  assign mis_mag = mis[MIS_W-1] ? $unsigned(-mis) : $unsigned(mis);
  assign in_tri  = mis_mag < MIS_W'(tol_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q <= 1'b0;
    end else if (v_q[4] && in_tri) begin
      hit_q <= 1'b1;
    end
  end

  assign sts_o.busy = |v_q;
  assign sts_o.hit  = hit_q;

endmodule
`default_nettype wire

// ===== src/pitu_ctrl.sv =====
// Controller: sequences loads and queries, holds the result register.
`default_nettype none
`include "point_in_triangle_union_defines.svh"
module pitu_ctrl #(
  parameter int unsigned MAX_TRIANGLES = pitu_pkg::MAX_TRIANGLES_DEF,
  localparam int unsigned IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        in_req_type_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output pitu_pkg::pitu_rsp_t              out_rsp_o,
  input  wire logic [pitu_pkg::COUNT_W-1:0] tri_count_i,
  output pitu_pkg::pitu_cmd_t              cmd_o,
  output logic [IDX_W-1:0]                 rd_idx_o,
  input  wire pitu_pkg::pitu_sts_t         sts_i
);
  import pitu_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TRIANGLES + 1);
  localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   n_clamp;
  logic [CMP_W-1:0]   count_ext;
  pitu_rsp_t          res_q, res_d;
  pitu_rsp_t          rsp_q, rsp_d;
  logic               out_valid_q, out_valid_d;
  logic               in_xfer;

  assign count_ext = CMP_W'(tri_count_i);
  assign n_clamp   = (count_ext > CMP_W'(MAX_TRIANGLES)) ? CNT_W'(MAX_TRIANGLES)
                                                        : CNT_W'(count_ext);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign rd_idx_o    = cnt_q[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          res_d.inside_res = 1'b0;
          if (in_req_type_i == REQ_QUERY) begin
            res_d.is_reply = 1'b1;
            if (n_clamp == '0) begin
              state_d = ST_DONE;
            end else begin
              cmd_o.start = 1'b1;
              cnt_d       = '0;
              n_d         = n_clamp;
              state_d     = ST_ISSUE;
            end
          end else begin
            res_d.is_reply = 1'b0;
            cmd_o.write    = 1'b1;
            state_d        = ST_DONE;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        cnt_d       = CNT_W'(cnt_q + 1'b1);
        if (cnt_d == n_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          res_d.inside_res = sts_i.hit;
          state_d          = ST_DONE;
        end
      end
      ST_DONE: begin
        // output register free or emptying this cycle
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          rsp_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    rsp_q <= rsp_d;
  end

  `PITU_ASSERT(a_issue_in_range, cmd_o.issue |-> (cnt_q < n_q))
  `PITU_ASSERT(a_idle_pipe_empty, (state_q == ST_IDLE) |-> !sts_i.busy)
  `PITU_ASSERT(a_load_to_done, (in_xfer && (in_req_type_i == REQ_LOAD)) |=> (state_q == ST_DONE))
  `PITU_ASSERT(a_valid_from_done, $rose(out_valid_o) |-> $past(state_q == ST_DONE))
  `PITU_ASSERT_NEVER(a_no_write_while_busy, cmd_o.write && sts_i.busy)

endmodule
`default_nettype wire

// ===== src/point_in_triangle_union.sv =====
// Top level: point membership test against a union of stored triangles.
//
// Input channel (in_valid_i / in_ready_o / in_req_i): one item per transfer.
// A load item (req_type 0) stores triangle ax..cy in slot; a query item
// (req_type 1) tests point_x/point_y against slots 0 .. n-1, n being
// triangle_count saturated to MAX_TRIANGLES.
// Output channel (out_valid_o / out_ready_i / out_rsp_o): exactly one
// result per input item, in order. Loads answer is_reply 0, inside_res 0.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_idx_i / cfg_data_i):
// always ready; index 0 is triangle_count, index 1 is tolerance.
// Timing: a load or an empty query goes straight to done; a query issues
// its slots, then drains. One slot per cycle is read into a six-stage area
// pipeline (memory read, differences, products, abs, sum, compare), so the
// slot count sets the query time; a new item is taken once the previous
// one has reached the output register.
// Reset: triangle_count 0, tolerance 1; the triangle store is not cleared
// and a slot must be loaded before any query reads it.
// Stall: a held result stays in the output register; the next item is
// still processed and waits for the register to free up.
`default_nettype none
module point_in_triangle_union #(
  parameter int unsigned MAX_TRIANGLES = pitu_pkg::MAX_TRIANGLES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire pitu_pkg::pitu_req_t            in_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output pitu_pkg::pitu_rsp_t                 out_rsp_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic                           cfg_idx_i,
  input  wire logic [pitu_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pitu_pkg::*;

  localparam int unsigned IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

  logic [COUNT_W-1:0] tri_count_q;
  logic [TOL_W-1:0]   tol_q;
  pitu_cmd_t          cmd;
  pitu_sts_t          sts;
  logic [IDX_W-1:0]   rd_idx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_count_q <= '0;
      tol_q       <= TOL_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        CFG_TRI_COUNT: tri_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_TOLERANCE: tol_q       <= cfg_data_i[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pitu_ctrl #(
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_type_i(in_req_i.req_type),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_o    (out_rsp_o),
    .tri_count_i  (tri_count_q),
    .cmd_o        (cmd),
    .rd_idx_o     (rd_idx),
    .sts_i        (sts)
  );

  pitu_dp #(
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .req_i   (in_req_i),
    .rd_idx_i(rd_idx),
    .tol_i   (tol_q),
    .sts_o   (sts)
  );

endmodule
`default_nettype wire
